### hdl/sdf_pkg.sv
// Shared types and constants for the stream duplicate filter.
// The token type carries one beat down the chain of compare cells.
// No dependencies.
package sdf_pkg;

   localparam int CAPACITY = 64;
   localparam int VALUE_W  = 32;

   typedef struct packed {
      logic               valid;
      logic [VALUE_W-1:0] value;
      logic               last;
      logic               found;     // matched a recorded entry upstream
      logic               recorded;  // written into an empty cell upstream
   } tok_type;

endpackage

### hdl/stream_duplicate_filter.sv
// Stream duplicate filter: marks repeated values within a list.
// Values enter on req_*; one result per value leaves on rsp_*.
// Each value passes through the register of every cell in the chain and then the result register.
// Throughput is one beat per cycle while the chain is not stalled: each value
// walks the chain of store cells one cell per cycle, comparing against one
// recorded entry per cell, so a new beat can enter right behind the previous one.
// A value not found is written into the first free cell it passes; if it
// finds no free cell it is kept, not recorded, and store_overflow is set.
// has_duplicate and store_overflow are sticky over a list and shown on
// every result including the tlast beat; the tlast beat clears each cell
// as it passes, and the flags after it leaves the chain.
// Reset empties all cells, the flags and the result register; no clearing
// pass is needed, the block takes beats right after reset.
// When a result is held and rsp_tready is low, the result stays and the whole chain stalls;
// req_tready follows the result register being free or being taken.
// Depends on sdf_pkg, sdf_cell and sdf_tail.
module stream_duplicate_filter
   import sdf_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [VALUE_W-1:0] req_tdata,   // [31:0] value
   input  logic               req_tlast,   // end_of_list
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [VALUE_W-1:0] rsp_tdata,   // [31:0] value_out
   output logic [2:0]         rsp_tuser,   // [0] keep, [1] has_duplicate, [2] store_overflow
   output logic               rsp_tlast    // last_out
);

   tok_type chain [CAPACITY+1];
   logic    advance;
   logic    keep;
   logic    dup;
   logic    ovf;

   assign req_tready = advance;

   // enter with no match and no claim yet
   assign chain[0] = {req_tvalid, req_tdata, req_tlast, 1'b0, 1'b0};

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      sdf_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .advance (advance),
         .up_tok  (chain[i]),
         .dn_tok  (chain[i+1])
      );
   end

   sdf_tail u_tail (
      .clock     (clock),
      .reset     (reset),
      .up_tok    (chain[CAPACITY]),
      .advance   (advance),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_value (rsp_tdata),
      .rsp_keep  (keep),
      .rsp_dup   (dup),
      .rsp_ovf   (ovf),
      .rsp_last  (rsp_tlast)
   );

   assign rsp_tuser = {ovf, dup, keep};

endmodule

### hdl/sdf_cell.sv
// One store cell of the duplicate filter: holds one recorded value and
// checks the passing token against it. Depends on sdf_pkg.
module sdf_cell
   import sdf_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    advance,
   input  tok_type up_tok,
   output tok_type dn_tok
);

   logic               used_ff, used_in;
   logic [VALUE_W-1:0] entry_ff, entry_in;
   tok_type            tok_ff, tok_in;
   logic               match;
   logic               claim;

   assign match = used_ff && (entry_ff == up_tok.value);
   assign claim = up_tok.valid && !up_tok.found && !up_tok.recorded && !used_ff;

   always_comb begin
      used_in  = used_ff;
      entry_in = entry_ff;
      tok_in   = tok_ff;
      if (advance) begin
         tok_in          = up_tok;
         tok_in.found    = up_tok.found || (up_tok.valid && match);
         tok_in.recorded = up_tok.recorded || claim;
         if (claim) begin
            used_in  = 1'b1;
            entry_in = up_tok.value;
         end
         // drop the list's entries as its last beat passes
         if (up_tok.valid && up_tok.last) begin
            used_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff      <= 1'b0;
         tok_ff.valid <= 1'b0;
      end else begin
         used_ff      <= used_in;
         tok_ff.valid <= tok_in.valid;
      end
      entry_ff        <= entry_in;
      tok_ff.value    <= tok_in.value;
      tok_ff.last     <= tok_in.last;
      tok_ff.found    <= tok_in.found;
      tok_ff.recorded <= tok_in.recorded;
   end

   assign dn_tok = tok_ff;

endmodule

### hdl/sdf_tail.sv
// Output stage of the duplicate filter: sticky list flags and the result
// register that feeds the rsp channel. Depends on sdf_pkg.
module sdf_tail
   import sdf_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  tok_type            up_tok,
   output logic               advance,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [VALUE_W-1:0] rsp_value,
   output logic               rsp_keep,
   output logic               rsp_dup,
   output logic               rsp_ovf,
   output logic               rsp_last
);

   logic               valid_ff, valid_in;
   logic [VALUE_W-1:0] value_ff, value_in;
   logic               keep_ff, keep_in;
   logic               dup_out_ff, dup_out_in;
   logic               ovf_out_ff, ovf_out_in;
   logic               last_ff, last_in;
   logic               dup_flag_ff, dup_flag_in;
   logic               ovf_flag_ff, ovf_flag_in;
   logic               take;
   logic               dup_now;
   logic               ovf_now;

   assign advance = !valid_ff || rsp_ready;
   assign take    = advance && up_tok.valid;
   assign dup_now = dup_flag_ff || up_tok.found;
   assign ovf_now = ovf_flag_ff || (!up_tok.found && !up_tok.recorded);

   always_comb begin
      valid_in    = advance ? up_tok.valid : valid_ff;
      value_in    = value_ff;
      keep_in     = keep_ff;
      dup_out_in  = dup_out_ff;
      ovf_out_in  = ovf_out_ff;
      last_in     = last_ff;
      dup_flag_in = dup_flag_ff;
      ovf_flag_in = ovf_flag_ff;
      if (take) begin
         value_in   = up_tok.value;
         keep_in    = !up_tok.found;
         dup_out_in = dup_now;
         ovf_out_in = ovf_now;
         last_in    = up_tok.last;
         // clear the flags after the list's last beat
         dup_flag_in = up_tok.last ? 1'b0 : dup_now;
         ovf_flag_in = up_tok.last ? 1'b0 : ovf_now;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= 1'b0;
         dup_flag_ff <= 1'b0;
         ovf_flag_ff <= 1'b0;
      end else begin
         valid_ff    <= valid_in;
         dup_flag_ff <= dup_flag_in;
         ovf_flag_ff <= ovf_flag_in;
      end
      value_ff   <= value_in;
      keep_ff    <= keep_in;
      dup_out_ff <= dup_out_in;
      ovf_out_ff <= ovf_out_in;
      last_ff    <= last_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_value = value_ff;
   assign rsp_keep  = keep_ff;
   assign rsp_dup   = dup_out_ff;
   assign rsp_ovf   = ovf_out_ff;
   assign rsp_last  = last_ff;

   a_drop_marks_dup: assert property (@(posedge clock) disable iff (reset)
      valid_ff && !keep_ff |-> dup_out_ff)
      else $error("dropped beat without duplicate flag");

   a_lost_sets_ovf: assert property (@(posedge clock) disable iff (reset)
      take && !up_tok.found && !up_tok.recorded |=> valid_ff && ovf_out_ff && keep_ff)
      else $error("unrecorded new value did not raise overflow");

   a_flags_clear: assert property (@(posedge clock) disable iff (reset)
      take && up_tok.last |=> !dup_flag_ff && !ovf_flag_ff)
      else $error("list flags not cleared after last beat");

   a_hold_stalled: assert property (@(posedge clock) disable iff (reset)
      valid_ff && !rsp_ready |=> valid_ff && $stable(value_ff) && $stable(keep_ff))
      else $error("result changed while stalled");

endmodule

### tb/sv/stream_duplicate_filter_tb.sv
// Self-checking testbench for stream_duplicate_filter: directed table, then random lists.
// Keeps its own model of the seen-value store and checks every result beat field by field.
// Depends on sdf_pkg and the stream_duplicate_filter RTL.
module stream_duplicate_filter_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import sdf_pkg::*;

   localparam int TOTAL_ITEMS  = 1350;
   localparam int PHASE_LEN    = 450;
   localparam int HOLD_CYCLES  = 400;
   localparam int DRAIN_CYCLES = 2 * (CAPACITY + 1) + 10;
   localparam int N_ROWS       = 13;

   // tuser layout on the result side
   localparam int FLAG_KEEP = 0;
   localparam int FLAG_DUP  = 1;
   localparam int FLAG_OVF  = 2;

   typedef enum int {LIST_POOL, LIST_WIDE, LIST_FILL, LIST_NOISE} list_kind_type;

   typedef struct packed {
      logic [VALUE_W-1:0] value;
      logic [2:0]         flags;   // [0] keep, [1] has_duplicate, [2] store_overflow
      logic               last;
   } filter_result_type;

   typedef struct packed {
      bit         checked;
      logic [2:0] flags;
   } typed_flags_type;

   typedef struct packed {
      logic [VALUE_W-1:0] value;
      logic               last;
      bit                 checked;
      logic [2:0]         flags;
   } table_row_type;

   logic               clock;
   logic               reset;
   logic               req_tvalid;
   logic               req_tready;
   logic [VALUE_W-1:0] req_tdata;
   logic               req_tlast;
   logic               rsp_tvalid;
   logic               rsp_tready;
   logic [VALUE_W-1:0] rsp_tdata;
   logic [2:0]         rsp_tuser;
   logic               rsp_tlast;

   // own copy of the list store
   logic [VALUE_W-1:0] known_values [CAPACITY];
   int                 known_count;
   logic               dup_seen;
   logic               full_miss;

   filter_result_type  expected_results [$];
   typed_flags_type    typed_flags_q [$];
   int                 items_sent;
   int                 error_count;
   bit                 hold_done;

   table_row_type directed_rows [N_ROWS] = '{
      '{32'h0000_0000, 1'b0, 1'b1, 3'b001},
      '{32'hFFFF_FFFF, 1'b0, 1'b1, 3'b001},
      '{32'h7FFF_FFFF, 1'b0, 1'b1, 3'b001},
      '{32'h8000_0000, 1'b0, 1'b1, 3'b001},
      '{32'h0000_0000, 1'b0, 1'b1, 3'b010},
      // flags on the last beat include that beat
      '{32'h8000_0000, 1'b1, 1'b1, 3'b010},
      // store and flags cleared after the last beat
      '{32'h8000_0000, 1'b0, 1'b1, 3'b001},
      '{32'h8000_0001, 1'b0, 1'b0, 3'b000},
      '{32'h8000_0000, 1'b1, 1'b1, 3'b010},
      '{32'h1234_5678, 1'b1, 1'b1, 3'b001},
      '{32'hA5A5_A5A5, 1'b0, 1'b0, 3'b000},
      '{32'h5A5A_5A5A, 1'b0, 1'b0, 3'b000},
      '{32'hA5A5_A5A5, 1'b1, 1'b0, 3'b000}
   };

   stream_duplicate_filter dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("== FAIL ==");
      $finish;
   end

   function automatic filter_result_type filter_step(input logic [VALUE_W-1:0] v,
                                                     input logic l);
      filter_result_type r;
      bit                hit;
      hit = 1'b0;
      for (int i = 0; i < known_count; i++) begin
         if (known_values[i] == v) hit = 1'b1;
      end
      if (hit) begin
         dup_seen = 1'b1;
      end else if (known_count < CAPACITY) begin
         known_values[known_count] = v;
         known_count++;
      end else begin
         full_miss = 1'b1;
      end
      r.value           = v;
      r.flags[FLAG_KEEP] = !hit;
      r.flags[FLAG_DUP]  = dup_seen;
      r.flags[FLAG_OVF]  = full_miss;
      r.last            = l;
      if (l) begin
         known_count = 0;
         dup_seen    = 1'b0;
         full_miss   = 1'b0;
      end
      return r;
   endfunction

   function automatic int idle_pct(input bit receiver);
      if (items_sent < PHASE_LEN) return receiver ? 60 : 18;
      if (items_sent < 2 * PHASE_LEN) return receiver ? 18 : 60;
      return 0;
   endfunction

   task automatic report_field(input string name, input logic [VALUE_W-1:0] want,
                               input logic [VALUE_W-1:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch: expected %h, got %h", $time, name, want, got);
         error_count++;
      end
   endtask

   // Monitor both channels at the edge; inputs move only by nonblocking assignment.
   always @(posedge clock) begin
      filter_result_type want;
      typed_flags_type   tf;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            want = filter_step(req_tdata, req_tlast);
            if (typed_flags_q.size() != 0) begin
               tf = typed_flags_q.pop_front();
               if (tf.checked) want.flags = tf.flags;
            end
            expected_results.insert(expected_results.size(), want);
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_results.size() == 0) begin
               $display("%0t: unexpected result beat: value %h tuser %b tlast %b",
                        $time, rsp_tdata, rsp_tuser, rsp_tlast);
               error_count++;
            end else begin
               want = expected_results.pop_front();
               report_field("value_out", want.value, rsp_tdata);
               report_field("keep", VALUE_W'(want.flags[FLAG_KEEP]),
                            VALUE_W'(rsp_tuser[FLAG_KEEP]));
               report_field("has_duplicate", VALUE_W'(want.flags[FLAG_DUP]),
                            VALUE_W'(rsp_tuser[FLAG_DUP]));
               report_field("store_overflow", VALUE_W'(want.flags[FLAG_OVF]),
                            VALUE_W'(rsp_tuser[FLAG_OVF]));
               report_field("last_out", VALUE_W'(want.last), VALUE_W'(rsp_tlast));
            end
         end
      end
   end

   // Receiver: random back-pressure, plus one long hold-off in the last phase.
   initial begin
      rsp_tready <= 1'b0;
      hold_done = 1'b0;
      forever begin
         if (!hold_done && items_sent >= 2 * PHASE_LEN + 40) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_done = 1'b1;
         end else begin
            rsp_tready <= ($urandom_range(0, 99) >= idle_pct(1'b1));
            @(posedge clock);
         end
      end
   end

   task automatic send_beat(input logic [VALUE_W-1:0] v, input logic l, input bit checked,
                            input logic [2:0] flags);
      typed_flags_type tf;
      while ($urandom_range(0, 99) < idle_pct(1'b0)) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      tf.checked = checked;
      tf.flags   = flags;
      typed_flags_q.insert(typed_flags_q.size(), tf);
      req_tvalid <= 1'b1;
      req_tdata  <= v;
      req_tlast  <= l;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
   endtask

   task automatic pause_until_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (expected_results.size() != 0) @(posedge clock);
   endtask

   // Fill or nearly fill the store, then mix new values, recorded repeats and unrecorded repeats.
   task automatic send_fill_list();
      logic [VALUE_W-1:0] base;
      logic [VALUE_W-1:0] v;
      int                 len;
      int                 pick;
      base = $urandom;
      len  = $urandom_range(CAPACITY - 2, CAPACITY + 16);
      for (int i = 0; i < len; i++) begin
         pick = $urandom_range(0, 2);
         if (i < CAPACITY) v = base + i;
         else if (pick == 0 || i == CAPACITY) v = base + 100 + i;
         else if (pick == 1) v = base + $urandom_range(0, CAPACITY - 1);
         else v = base + 100 + $urandom_range(CAPACITY, i - 1);
         send_beat(v, i == len - 1, 1'b0, 3'b000);
      end
   endtask

   task automatic send_random_list(input list_kind_type kind);
      logic [VALUE_W-1:0] base;
      logic [VALUE_W-1:0] v;
      logic [VALUE_W-1:0] history [16];
      logic               l;
      int                 len;
      base = $urandom;
      case (kind)
         LIST_POOL: begin
            len = $urandom_range(1, 24);
            for (int i = 0; i < len; i++)
               send_beat(base + $urandom_range(0, 5), i == len - 1, 1'b0, 3'b000);
         end
         LIST_WIDE: begin
            len = $urandom_range(1, 16);
            for (int i = 0; i < len; i++) begin
               if (i > 0 && $urandom_range(0, 3) == 0) v = history[$urandom_range(0, i - 1)];
               else v = $urandom;
               history[i] = v;
               send_beat(v, i == len - 1, 1'b0, 3'b000);
            end
         end
         LIST_FILL: begin
            send_fill_list();
         end
         default: begin
            // end_of_list at random, so lists run on into the next one
            len = $urandom_range(1, 30);
            for (int i = 0; i < len; i++) begin
               l = ($urandom_range(0, 4) == 0);
               send_beat(base + $urandom_range(0, 9), l, 1'b0, 3'b000);
            end
         end
      endcase
   endtask

   initial begin
      int            roll;
      list_kind_type kind;
      reset       <= 1'b1;
      req_tvalid  <= 1'b0;
      req_tdata   <= '0;
      req_tlast   <= 1'b0;
      items_sent  = 0;
      error_count = 0;
      known_count = 0;
      dup_seen    = 1'b0;
      full_miss   = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      for (int r = 0; r < N_ROWS; r++)
         send_beat(directed_rows[r].value, directed_rows[r].last, directed_rows[r].checked,
                   directed_rows[r].flags);
      pause_until_drained();

      send_fill_list();
      while (items_sent < TOTAL_ITEMS) begin
         roll = $urandom_range(0, 99);
         if (roll < 40) kind = LIST_POOL;
         else if (roll < 65) kind = LIST_WIDE;
         else if (roll < 75) kind = LIST_FILL;
         else kind = LIST_NOISE;
         send_random_list(kind);
      end

      pause_until_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0 && expected_results.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
